// ----- hdl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_POP    = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CMP_EQ = 3'd0,
        CMP_GE = 3'd1,
        CMP_LE = 3'd2,
        CMP_NE = 3'd3,
        CMP_GT = 3'd4,
        CMP_LT = 3'd5
    } t_cmp_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic    ins_en;
        logic    del_en;
        logic    is_pop;
        t_cmp_op op;
    } t_cmd;

    // Flags handed from one cell to the next one toward the back
    typedef struct packed {
        logic after;  // cell sits at or past the insert point
        logic hit;    // this cell or one in front of it matched the delete test
    } t_link;

endpackage

// ----- hdl/spq_cell.sv -----
// One slot of the sorted queue: holds an entry, compares, shifts left or right.
module spq_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                     i_clk,
    input  spq_pkg::t_cmd            i_cmd,
    input  logic [PRIORITY_BITS-1:0] i_value,
    input  logic                     i_occupied,
    input  logic                     i_front,
    input  spq_pkg::t_link           i_left_link,
    input  logic [PRIORITY_BITS-1:0] i_left_entry,
    input  logic [PRIORITY_BITS-1:0] i_right_entry,
    input  logic [PRIORITY_BITS-1:0] i_removed_acc,
    output spq_pkg::t_link           o_link,
    output logic [PRIORITY_BITS-1:0] o_entry,
    output logic [PRIORITY_BITS-1:0] o_removed_acc
);
    import spq_pkg::*;

    logic [PRIORITY_BITS-1:0] r_entry;
    logic [PRIORITY_BITS-1:0] n_entry;
    logic                     test_pass;
    logic                     match;
    logic                     first;

    always_comb begin
        unique case (i_cmd.op)
            CMP_EQ:  test_pass = (r_entry == i_value);
            CMP_GE:  test_pass = (r_entry >= i_value);
            CMP_LE:  test_pass = (r_entry <= i_value);
            CMP_NE:  test_pass = (r_entry != i_value);
            CMP_GT:  test_pass = (r_entry >  i_value);
            CMP_LT:  test_pass = (r_entry <  i_value);
            default: test_pass = 1'b0;
        endcase
    end

    assign match        = i_occupied & (i_cmd.is_pop ? i_front : test_pass);
    assign first        = match & ~i_left_link.hit;
    assign o_link.hit   = i_left_link.hit | match;
    assign o_link.after = ~i_occupied | (r_entry > i_value);
    assign o_entry      = r_entry;
    assign o_removed_acc = i_removed_acc | (first ? r_entry : '0);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins_en && o_link.after) begin
            n_entry = i_left_link.after ? i_left_entry : i_value;
        end else if (i_cmd.del_en && o_link.hit) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hdl/sorted_priority_queue_table.sv -----
// An accepted transfer's result and count are registered; all cells compare and shift
// together. Throughput: one item per cycle while o_in_ready is high.
// The critical path is the hit and removed-value chain along the row of DEPTH cells.
// Reset clears the entry count and the output valid; cell contents stay as they
// are and are only read below the count, so no clearing pass is needed.
module sorted_priority_queue_table #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_mode,
    input  logic [PRIORITY_BITS-1:0]         i_priority_value,
    input  logic [2:0]                       i_compare_op,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic [PRIORITY_BITS-1:0]         o_removed_priority,
    output logic [$clog2(DEPTH+1)-1:0]       o_entry_count
);
    import spq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Handshake and output register
    logic                     accept;
    logic                     r_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [PRIORITY_BITS-1:0] r_removed;
    logic [PRIORITY_BITS-1:0] n_removed;
    logic [COUNT_W-1:0]       r_count;
    logic [COUNT_W-1:0]       n_count;

    // Cell row
    t_cmd                     cmd;
    t_link                    link      [DEPTH];
    logic [PRIORITY_BITS-1:0] entry     [DEPTH];
    logic [PRIORITY_BITS-1:0] acc       [DEPTH];
    logic                     full;
    logic                     empty;
    logic                     any_hit;
    t_mode                    mode;

    // A new transfer is taken whenever the output slot is free or being drained
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;

    assign mode  = t_mode'(i_mode);
    assign full  = (r_count == COUNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign cmd.ins_en = accept & (mode == MODE_INSERT) & ~full;
    assign cmd.del_en = accept & ((mode == MODE_DELETE) | (mode == MODE_POP)) & ~empty;
    assign cmd.is_pop = (mode == MODE_POP);
    assign cmd.op     = t_cmp_op'(i_compare_op);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_link                    left_link;
            logic [PRIORITY_BITS-1:0] left_entry;
            logic [PRIORITY_BITS-1:0] right_entry;
            logic [PRIORITY_BITS-1:0] acc_in;

            if (gi == 0) begin : g_front
                assign left_link  = '0;
                assign left_entry = i_priority_value;
                assign acc_in     = '0;
            end else begin : g_inner
                assign left_link  = link[gi-1];
                assign left_entry = entry[gi-1];
                assign acc_in     = acc[gi-1];
            end

            // The back cell refills with its own value; it sits past the count anyway
            if (gi == DEPTH - 1) begin : g_back
                assign right_entry = entry[gi];
            end else begin : g_mid
                assign right_entry = entry[gi+1];
            end

            spq_cell #(
                .PRIORITY_BITS(PRIORITY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_value      (i_priority_value),
                .i_occupied   (COUNT_W'(gi) < r_count),
                .i_front      (gi == 0),
                .i_left_link  (left_link),
                .i_left_entry (left_entry),
                .i_right_entry(right_entry),
                .i_removed_acc(acc_in),
                .o_link       (link[gi]),
                .o_entry      (entry[gi]),
                .o_removed_acc(acc[gi])
            );
        end
    endgenerate

    assign any_hit = link[DEPTH-1].hit;

    // Result and count update for the item being taken
    always_comb begin
        n_status  = ST_DONE;
        n_removed = '0;
        n_count   = r_count;
        unique case (1'b1)
            mode == MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            (mode == MODE_DELETE) || (mode == MODE_POP): begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (any_hit) begin
                    n_removed = acc[DEPTH-1];
                    n_count   = r_count - COUNT_W'(1);
                end else begin
                    n_status = ST_NOMATCH;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_removed_priority = r_removed;
    // Count only moves on a new transfer, which also replaces the pending result
    assign o_entry_count      = r_count;

endmodule
